// ===== hw/rtl/cgsl_pkg.sv =====
// Package for the colour gradient stop lookup block.
// Holds item kind codes, result status codes and channel widths.
// No dependencies.
`default_nettype none

package cgsl_pkg;

    // Width of one colour channel and of a packed RGBA word
    localparam int CHAN_BITS = 8;
    localparam int NUM_CHANS = 4;
    localparam int RGBA_BITS = CHAN_BITS * NUM_CHANS;

    // Item kind carried in tuser of the input stream
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status carried in tuser of the output stream
    typedef enum logic [1:0] {
        ST_COLOR = 2'd0,
        ST_ADDED = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage : cgsl_pkg

`default_nettype wire

// ===== hw/rtl/cgsl_stop_mem.sv =====
// Stop table storage: one write port, one read port, registered read data.
// Each entry holds a colour word above a position. No package dependency.
`default_nettype none

module cgsl_stop_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 48
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [W-1:0]  wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry; the read data is registered
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule : cgsl_stop_mem

`default_nettype wire

// ===== hw/rtl/cgsl_blend.sv =====
// Per-channel linear blend with round-half-up division by the stop span.
// Works the four channels in turn: multiply, sum, then one quotient bit a cycle.
// Depends on cgsl_pkg.
`default_nettype none

module cgsl_blend
    import cgsl_pkg::*;
#(
    parameter int PW = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [RGBA_BITS-1:0] a_rgba,
    input  wire logic [RGBA_BITS-1:0] b_rgba,
    input  wire logic [PW-1:0]        span,
    input  wire logic [PW-1:0]        offset,
    output logic                      done,
    output logic      [RGBA_BITS-1:0] rgba
);

    localparam int NW = PW + CHAN_BITS;
    localparam int SW = $clog2(CHAN_BITS);
    localparam int KW = $clog2(NUM_CHANS);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_SUM  = 4'b0100,
        B_DIV  = 4'b1000
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [RGBA_BITS-1:0] a_reg, a_next;
    logic [RGBA_BITS-1:0] b_reg, b_next;
    logic [PW-1:0]        span_reg, span_next;
    logic [PW-1:0]        offset_reg, offset_next;
    logic [KW-1:0]        chan_reg, chan_next;
    logic [NW-1:0]        prod_a_reg, prod_a_next;
    logic [NW-1:0]        prod_b_reg, prod_b_next;
    logic [NW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        div_reg, div_next;
    logic [CHAN_BITS-1:0] quo_reg, quo_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [RGBA_BITS-1:0] res_reg, res_next;
    logic                 done_reg, done_next;

    logic [CHAN_BITS-1:0] ca, cb;
    logic [PW-1:0]        rest;
    logic [NW-1:0]        prod_a_w, prod_b_w;
    logic                 take;
    logic [CHAN_BITS-1:0] quo_w;

    // Channel operands and the two weighted products
    assign ca       = a_reg[chan_reg*CHAN_BITS +: CHAN_BITS];
    assign cb       = b_reg[chan_reg*CHAN_BITS +: CHAN_BITS];
    assign rest     = span_reg - offset_reg;
    assign prod_a_w = {{PW{1'b0}}, ca} * {{CHAN_BITS{1'b0}}, rest};
    assign prod_b_w = {{PW{1'b0}}, cb} * {{CHAN_BITS{1'b0}}, offset_reg};

    // One restoring division step
    assign take  = rem_reg >= div_reg;
    assign quo_w = {quo_reg[CHAN_BITS-2:0], take};

    always_comb begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        span_next   = span_reg;
        offset_next = offset_reg;
        chan_next   = chan_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (start) begin
                    a_next      = a_rgba;
                    b_next      = b_rgba;
                    span_next   = span;
                    offset_next = offset;
                    chan_next   = '0;
                    state_next  = B_MUL;
                end
            end
            B_MUL: begin
                prod_a_next = prod_a_w;
                prod_b_next = prod_b_w;
                state_next  = B_SUM;
            end
            B_SUM: begin
                // Add half the span so the truncating divide rounds half up
                rem_next   = prod_a_reg + prod_b_reg + NW'(span_reg >> 1);
                div_next   = {1'b0, span_reg, {(CHAN_BITS-1){1'b0}}};
                quo_next   = '0;
                step_next  = SW'(CHAN_BITS - 1);
                state_next = B_DIV;
            end
            B_DIV: begin
                if (take) begin
                    rem_next = rem_reg - div_reg;
                end
                quo_next  = quo_w;
                div_next  = div_reg >> 1;
                step_next = step_reg - SW'(1);
                if (step_reg == '0) begin
                    res_next[chan_reg*CHAN_BITS +: CHAN_BITS] = quo_w;
                    if (chan_reg == KW'(NUM_CHANS - 1)) begin
                        done_next  = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        chan_next  = chan_reg + KW'(1);
                        state_next = B_MUL;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        span_reg   <= span_next;
        offset_reg <= offset_next;
        chan_reg   <= chan_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        res_reg    <= res_next;
    end

    assign done = done_reg;
    assign rgba = res_reg;

endmodule : cgsl_blend

`default_nettype wire

// ===== hw/rtl/color_gradient_stop_lookup_top.sv =====
// Colour gradient stop lookup: sorted stop table in a one-read one-write memory.
// Blended lookup: scan the stops, then the blend unit works the channels in turn
// (multiply, sum, divide) and raises done. Other lookups end on the scan, or at once
// on an empty table. Add: scan, shift the entries above the slot if needed, then put.
// One item at a time; the next is taken once the result sits in the output register.
// Reset clears state, stop count and output valid, not the table; entries are written before read.
`default_nettype none

module color_gradient_stop_lookup_top
    import cgsl_pkg::*;
#(
    parameter int MAX_STOPS     = 16,
    parameter int POSITION_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // s_tdata fields from bit 0: position, stop_rgba, zero padding
    input  wire logic [((POSITION_BITS + RGBA_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser fields from bit 0: kind
    input  wire logic                                                  s_tuser,
    input  wire logic                                                  s_tvalid,
    output logic                                                       s_tready,
    // m_tdata fields from bit 0: red, green, blue, alpha
    output logic      [RGBA_BITS-1:0]                                  m_tdata,
    // m_tuser fields from bit 0: status
    output logic      [1:0]                                            m_tuser,
    output logic                                                       m_tvalid,
    input  wire logic                                                  m_tready
);

    localparam int PW = POSITION_BITS;
    localparam int EW = PW + RGBA_BITS;
    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PUT   = 6'b001000,
        S_BLEND = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic                 kind_reg, kind_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [RGBA_BITS-1:0] rgba_reg, rgba_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        at_reg, at_next;
    logic [EW-1:0]        prev_reg, prev_next;
    status_t              res_status_reg, res_status_next;
    logic [RGBA_BITS-1:0] res_rgba_reg, res_rgba_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;
    logic [RGBA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data;
    logic [PW-1:0]        rd_pos;
    logic [RGBA_BITS-1:0] rd_rgba;
    logic [PW-1:0]        prev_pos;
    logic                 hit;
    logic                 last;
    logic                 blend_start;
    logic                 blend_done;
    logic [RGBA_BITS-1:0] blend_rgba;
    logic [PW-1:0]        span;
    logic [PW-1:0]        offset;

    cgsl_stop_mem #(
        .DEPTH (MAX_STOPS),
        .AW    (AW),
        .W     (EW)
    ) u_stop_mem (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cgsl_blend #(
        .PW (PW)
    ) u_blend (
        .clk    (aclk),
        .rst_n  (aresetn),
        .start  (blend_start),
        .a_rgba (prev_reg[EW-1:PW]),
        .b_rgba (rd_rgba),
        .span   (span),
        .offset (offset),
        .done   (blend_done),
        .rgba   (blend_rgba)
    );

    // Split the entry under inspection and compare against the item position
    assign rd_pos   = rd_data[PW-1:0];
    assign rd_rgba  = rd_data[EW-1:PW];
    assign prev_pos = prev_reg[PW-1:0];
    assign span     = rd_pos - prev_pos;
    assign offset   = pos_reg - prev_pos;
    assign hit      = (kind_reg == KIND_LOOKUP) ? (pos_reg < rd_pos) : (rd_pos >= pos_reg);
    assign last     = CW'(idx_reg) == (count_reg - CW'(1));

    assign s_tready = state_reg == S_IDLE;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        rgba_next       = rgba_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_rgba_next   = res_rgba_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        // Prefetch the following entry while scanning
        rd_addr         = idx_reg + AW'(1);
        wr_en           = 1'b0;
        wr_addr         = at_reg;
        wr_data         = {rgba_reg, pos_reg};
        blend_start     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (s_tvalid) begin
                    kind_next = s_tuser;
                    pos_next  = s_tdata[PW-1:0];
                    rgba_next = s_tdata[EW-1:PW];
                    idx_next  = '0;
                    at_next   = '0;
                    if (count_reg != '0) begin
                        state_next = S_SCAN;
                    end else if (s_tuser == KIND_LOOKUP) begin
                        // Empty table gives a zero colour
                        res_status_next = ST_COLOR;
                        res_rgba_next   = '0;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    if (kind_reg == KIND_LOOKUP) begin
                        if (hit && idx_reg != '0) begin
                            blend_start = 1'b1;
                            state_next  = S_BLEND;
                        end else begin
                            // Below the first stop or past the last one
                            res_status_next = ST_COLOR;
                            res_rgba_next   = rd_rgba;
                            state_next      = S_OUT;
                        end
                    end else if (hit && rd_pos == pos_reg) begin
                        res_status_next = ST_DUP;
                        res_rgba_next   = '0;
                        state_next      = S_OUT;
                    end else if (count_reg == CW'(MAX_STOPS)) begin
                        res_status_next = ST_FULL;
                        res_rgba_next   = '0;
                        state_next      = S_OUT;
                    end else if (hit) begin
                        // Open a slot: move entries up from the top down
                        at_next    = idx_reg;
                        idx_next   = count_reg[AW-1:0] - AW'(1);
                        rd_addr    = count_reg[AW-1:0] - AW'(1);
                        state_next = S_SHIFT;
                    end else begin
                        at_next    = count_reg[AW-1:0];
                        state_next = S_PUT;
                    end
                end else begin
                    prev_next = rd_data;
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                wr_data = rd_data;
                if (idx_reg == at_reg) begin
                    state_next = S_PUT;
                end else begin
                    idx_next = idx_reg - AW'(1);
                    rd_addr  = idx_reg - AW'(1);
                end
            end
            S_PUT: begin
                wr_en           = 1'b1;
                count_next      = count_reg + CW'(1);
                res_status_next = ST_ADDED;
                res_rgba_next   = '0;
                state_next      = S_OUT;
            end
            S_BLEND: begin
                if (blend_done) begin
                    res_status_next = ST_COLOR;
                    res_rgba_next   = blend_rgba;
                    state_next      = S_OUT;
                end
            end
            S_OUT: begin
                // Hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = res_rgba_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        rgba_reg       <= rgba_next;
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_rgba_reg   <= res_rgba_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : color_gradient_stop_lookup_top

`default_nettype wire

// ===== hw/rtl/cgsl_checker.sv =====
// Port-level checks for the colour gradient stop lookup top level, and its bind.
// Depends on cgsl_pkg and color_gradient_stop_lookup_top.
`default_nettype none

module cgsl_checker
    import cgsl_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [RGBA_BITS-1:0] m_tdata,
    input wire logic [1:0]           m_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    logic       s_xfer;
    logic       m_xfer;
    logic [1:0] pend_reg, pend_next;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // Track items taken in whose result transfer is still to come
    always_comb begin
        pend_next = pend_reg;
        if (s_xfer && !m_xfer) begin
            pend_next = pend_reg + 2'd1;
        end else if (!s_xfer && m_xfer) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result without an item behind it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result with no pending item");

    // At most one item in work plus one result waiting
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> pend_reg != 2'd2 || m_xfer)
        else $error("more than two items in flight");

    // Add results carry zero channels
    a_add_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'(ST_COLOR) |-> m_tdata == '0)
        else $error("non-zero channels on an add result");

endmodule : cgsl_checker

bind color_gradient_stop_lookup_top cgsl_checker u_cgsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

// ===== verif/cgsl_result_checker.sv =====
// Result checker for the colour gradient stop lookup block.
// Watches both stream channels, keeps its own sorted stop table and compares results.
// Depends on cgsl_pkg for status codes, item kinds and channel widths.

module cgsl_result_checker
    import cgsl_pkg::*;
#(
    parameter int MAX_STOPS     = 16,
    parameter int POSITION_BITS = 16,
    parameter int TDATA_BITS    = ((POSITION_BITS + RGBA_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata fields from bit 0: position, stop_rgba, zero padding
    input  wire logic [TDATA_BITS-1:0] s_tdata,
    // s_tuser fields from bit 0: kind
    input  wire logic                  s_tuser,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // m_tdata fields from bit 0: red, green, blue, alpha
    input  wire logic [RGBA_BITS-1:0]  m_tdata,
    // m_tuser fields from bit 0: status
    input  wire logic [1:0]            m_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    output int unsigned                mismatch_count,
    output int unsigned                results_pending
);

    typedef struct packed {
        status_t               status;
        logic [RGBA_BITS-1:0]  rgba;
    } color_result_t;

    // Own copy of the stop table, sorted by strictly increasing position
    logic [POSITION_BITS-1:0] stop_pos [MAX_STOPS];
    logic [RGBA_BITS-1:0]     stop_col [MAX_STOPS];
    int unsigned              stop_total = 0;

    color_result_t            expected_colors [$];
    color_result_t            want;
    int unsigned              fault_total = 0;
    string                    chan_name [NUM_CHANS] = '{"red", "green", "blue", "alpha"};

    // Apply one item to the stop table and work out the result it should give
    function automatic color_result_t apply_stop_item(
        input logic                     kind,
        input logic [POSITION_BITS-1:0] pos,
        input logic [RGBA_BITS-1:0]     rgba
    );
        color_result_t   r;
        int unsigned     at;
        longint unsigned d, n, ca, cb, v;
        r.status = ST_COLOR;
        r.rgba   = '0;
        if (kind == KIND_ADD) begin
            // Duplicate check comes before the full check
            for (int i = 0; i < stop_total; i++) begin
                if (stop_pos[i] == pos) begin
                    r.status = ST_DUP;
                    return r;
                end
            end
            if (stop_total >= MAX_STOPS) begin
                r.status = ST_FULL;
                return r;
            end
            at = 0;
            while (at < stop_total && stop_pos[at] < pos)
                at++;
            for (int i = stop_total; i > at; i--) begin
                stop_pos[i] = stop_pos[i-1];
                stop_col[i] = stop_col[i-1];
            end
            stop_pos[at] = pos;
            stop_col[at] = rgba;
            stop_total++;
            r.status = ST_ADDED;
            return r;
        end
        if (stop_total == 0)
            return r;
        if (pos <= stop_pos[0]) begin
            r.rgba = stop_col[0];
            return r;
        end
        // Blend between the first stop above the position and the one below it
        for (int i = 1; i < stop_total; i++) begin
            if (pos < stop_pos[i]) begin
                d = stop_pos[i] - stop_pos[i-1];
                n = pos - stop_pos[i-1];
                for (int k = 0; k < NUM_CHANS; k++) begin
                    ca = stop_col[i-1][k*CHAN_BITS +: CHAN_BITS];
                    cb = stop_col[i][k*CHAN_BITS +: CHAN_BITS];
                    v  = (ca * (d - n) + cb * n + d / 2) / d;
                    r.rgba[k*CHAN_BITS +: CHAN_BITS] = v[CHAN_BITS-1:0];
                end
                return r;
            end
        end
        r.rgba = stop_col[stop_total-1];
        return r;
    endfunction

    // Check each result transfer first, then record the expectation of each input transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            stop_total = 0;
            expected_colors.delete();
            results_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d colour %h",
                             $time, m_tuser, m_tdata);
                    fault_total++;
                end else begin
                    want = expected_colors.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fault_total++;
                    end
                    for (int k = 0; k < NUM_CHANS; k++) begin
                        if (m_tdata[k*CHAN_BITS +: CHAN_BITS]
                                !== want.rgba[k*CHAN_BITS +: CHAN_BITS]) begin
                            $display("%0t: %s mismatch, expected %0d actual %0d",
                                     $time, chan_name[k],
                                     want.rgba[k*CHAN_BITS +: CHAN_BITS],
                                     m_tdata[k*CHAN_BITS +: CHAN_BITS]);
                            fault_total++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_colors.push_back(apply_stop_item(s_tuser,
                    s_tdata[POSITION_BITS-1:0], s_tdata[POSITION_BITS +: RGBA_BITS]));
            results_pending <= expected_colors.size();
        end
        mismatch_count <= fault_total;
    end

endmodule : cgsl_result_checker

// ===== verif/color_gradient_stop_lookup_top_test.sv =====
// Testbench top for the colour gradient stop lookup block.
// Drives add and lookup items under several idle and stall mixes and gives the verdict.
// Depends on cgsl_pkg, color_gradient_stop_lookup_top and cgsl_result_checker.

module color_gradient_stop_lookup_top_test;
    import cgsl_pkg::*;

    localparam int     MAX_STOPS        = 16;
    localparam int     POSITION_BITS    = 16;
    localparam int     TDATA_BITS       = ((POSITION_BITS + RGBA_BITS + 7) / 8) * 8;
    localparam int     ITEMS_PER_PHASE  = 120;
    localparam int     SETTLE_CYCLES    = 100;
    localparam longint TIMEOUT_CYCLES   = 1000000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [TDATA_BITS-1:0] s_tdata  = '0;
    logic                  s_tuser  = KIND_ADD;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [RGBA_BITS-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    int unsigned           mismatch_count;
    int unsigned           results_pending;
    int                    sender_idle_pct = 0;
    int                    recv_stall_pct  = 0;
    logic [POSITION_BITS-1:0] placed_positions [$];

    color_gradient_stop_lookup_top #(
        .MAX_STOPS     (MAX_STOPS),
        .POSITION_BITS (POSITION_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    cgsl_result_checker #(
        .MAX_STOPS     (MAX_STOPS),
        .POSITION_BITS (POSITION_BITS)
    ) checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel at random, per cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop if the block hangs
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("DONE: errors detected");
        $finish;
    end

    // Optionally idle, then hold one item on the input channel until its transfer
    task automatic send_item(input logic kind, input logic [POSITION_BITS-1:0] pos,
                             input logic [RGBA_BITS-1:0] rgba);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= TDATA_BITS'({rgba, pos});
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_ADD)
            placed_positions.push_back(pos);
    endtask

    // Drop valid and hold off until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
    endtask

    // Random item: positions often near stops already placed, so brackets and duplicates occur
    task automatic send_random_item();
        logic                     kind;
        logic [POSITION_BITS-1:0] pos;
        logic [RGBA_BITS-1:0]     rgba;
        int                       pick;
        kind = ($urandom_range(99) < 30) ? KIND_ADD : KIND_LOOKUP;
        pick = $urandom_range(9);
        if (placed_positions.size() != 0 && pick < 4) begin
            pos = placed_positions[$urandom_range(placed_positions.size() - 1)];
            if (kind == KIND_LOOKUP)
                pos = pos + POSITION_BITS'($urandom_range(2)) - POSITION_BITS'(1);
        end else if (pick == 4) begin
            pos = '0;
        end else if (pick == 5) begin
            pos = '1;
        end else begin
            pos = POSITION_BITS'($urandom);
        end
        case ($urandom_range(7))
            0:       rgba = '0;
            1:       rgba = '1;
            default: rgba = $urandom;
        endcase
        send_item(kind, pos, rgba);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Lookups on an empty table
        send_item(KIND_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000);
        // Two stops, then a duplicate position
        send_item(KIND_ADD,    16'h4000, 32'h0000_0000);
        send_item(KIND_ADD,    16'hC000, 32'hFFFF_FFFF);
        send_item(KIND_ADD,    16'h4000, 32'h1234_5678);
        // Below, at, between and past the stops
        send_item(KIND_LOOKUP, 16'h0000, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'h4000, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'h4001, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'h8000, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'hC000, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000);
        // Narrow bracket: exact half rounds up
        send_item(KIND_ADD,    16'h2000, 32'h80FF_0001);
        send_item(KIND_ADD,    16'h2002, 32'h7F00_FF02);
        send_item(KIND_LOOKUP, 16'h2001, 32'h0000_0000);
        // Stops at both ends of the range
        send_item(KIND_ADD,    16'h0000, 32'hA5A5_5A5A);
        send_item(KIND_ADD,    16'hFFFF, 32'h5A5A_A5A5);
        send_item(KIND_LOOKUP, 16'h0000, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000);
        send_item(KIND_LOOKUP, 16'h3000, 32'h0000_0000);
        drain_results();

        // Random items under each idle and stall mix, draining between mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random_item();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule : color_gradient_stop_lookup_top_test
